// ===== rtl/b64d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SLASH   = 8'h2f;

  localparam logic [7:0] LOWER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  // Bit 6 set marks a character outside the alphabet
  localparam logic [6:0] SEXTET_NONE = 7'h40;

  // One decoded group handed from the front to the back
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] count;
    logic       eom;
  } job_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = SEXTET_NONE;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = {1'b0, 6'(c - CH_UPPER_A)};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r = {1'b0, 6'(c - CH_LOWER_A + LOWER_BASE)};
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      r = {1'b0, 6'(c - CH_DIGIT_0 + DIGIT_BASE)};
    end else if (c == CH_PLUS) begin
      r = {1'b0, SEXTET_PLUS};
    end else if (c == CH_SLASH) begin
      r = {1'b0, SEXTET_SLASH};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/b64d_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_front
// Classifies characters, gathers sextets and builds decoded groups.
// ----------------------------------------------------------------------------
module b64d_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    char_code,
  input  wire logic          end_of_message,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          q_full,
  output logic               q_push,
  output b64d_pkg::job_t     q_data
);

  logic [5:0] sextet_store [3];
  logic [1:0] group_count;
  logic [1:0] group_count_next;

  logic       accept;
  logic [6:0] sext;
  logic       is_valid;
  logic       group_full;
  logic [2:0] cnt_new;
  logic [5:0] s0, s1, s2, s3;
  logic [1:0] n_bytes;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign sext       = b64d_pkg::sextet_of(char_code);
  assign is_valid   = !sext[6];
  assign group_full = is_valid && (group_count == 2'd3);
  assign cnt_new    = is_valid ? ({1'b0, group_count} + 3'd1) : {1'b0, group_count};

  // merge the incoming sextet into the view of the held group
  assign s0 = (is_valid && group_count == 2'd0) ? sext[5:0] : sextet_store[0];
  assign s1 = (is_valid && group_count == 2'd1) ? sext[5:0] : sextet_store[1];
  assign s2 = (is_valid && group_count == 2'd2) ? sext[5:0] : sextet_store[2];
  assign s3 = group_full ? sext[5:0] : 6'd0;

  always_comb begin
    if (group_full) begin
      n_bytes = 2'd3;
    end else if (end_of_message && cnt_new > 3'd1) begin
      n_bytes = 2'(cnt_new - 3'd1);
    end else begin
      n_bytes = 2'd0;
    end
  end

  always_comb begin
    q_data.b0    = {s0, s1[5:4]};
    q_data.b1    = {s1[3:0], s2[5:2]};
    q_data.b2    = {s2[1:0], s3};
    q_data.count = n_bytes;
    q_data.eom   = end_of_message;
  end

  assign q_push = accept && (n_bytes != 2'd0);

  always_comb begin
    group_count_next = group_count;
    if (accept) begin
      if (group_full || end_of_message) begin
        group_count_next = 2'd0;
      end else begin
        group_count_next = cnt_new[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= 2'd0;
    end else begin
      group_count <= group_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_valid && !group_full) begin
      sextet_store[group_count] <= sext[5:0];
    end
  end

`ifndef SYNTHESIS
  a_eom_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_message) |=> (group_count == 2'd0))
    else $error("group not cleared after end of message");
`endif

endmodule
`default_nettype wire

// ===== rtl/b64d_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_queue
// Short queue of decoded groups between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire b64d_pkg::job_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output b64d_pkg::job_t      pop_data
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  b64d_pkg::job_t entries [DEPTH];
  logic [ADDR_W:0] wr_ptr;
  logic [ADDR_W:0] rd_ptr;

  assign valid    = (wr_ptr != rd_ptr);
  assign full     = (wr_ptr[ADDR_W] != rd_ptr[ADDR_W]) &&
                    (wr_ptr[ADDR_W-1:0] == rd_ptr[ADDR_W-1:0]);
  assign pop_data = entries[rd_ptr[ADDR_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr[ADDR_W-1:0]] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/b64d_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_back
// Takes decoded groups from the queue and sends them out one byte per beat.
// ----------------------------------------------------------------------------
module b64d_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire b64d_pkg::job_t q_data,
  output logic                q_pop,
  output logic [7:0]          data_byte,
  output logic                last_of_run,
  output logic                message_done,
  output logic                out_valid,
  input  wire logic           out_ready
);

  b64d_pkg::job_t cur;
  logic           busy;
  logic           busy_next;
  logic [1:0]     idx;
  logic [1:0]     idx_next;

  logic take;
  logic finish;
  logic load;

  assign out_valid    = busy;
  assign last_of_run  = (idx == (cur.count - 2'd1));
  assign message_done = last_of_run && cur.eom;

  always_comb begin
    case (idx)
      2'd0:    data_byte = cur.b0;
      2'd1:    data_byte = cur.b1;
      default: data_byte = cur.b2;
    endcase
  end

  assign take   = out_valid && out_ready;
  assign finish = take && last_of_run;
  // refill straight behind the final beat of a group
  assign load   = q_valid && (!busy || finish);
  assign q_pop  = load;

  always_comb begin
    busy_next = busy;
    idx_next  = idx;
    if (load) begin
      busy_next = 1'b1;
      idx_next  = 2'd0;
    end else if (finish) begin
      busy_next = 1'b0;
    end else if (take) begin
      idx_next = idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else begin
      busy <= busy_next;
      idx  <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

`ifndef SYNTHESIS
  a_group_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cur.count != 2'd0 && idx < cur.count))
    else $error("byte index outside group");
`endif

endmodule
`default_nettype wire

// ===== rtl/base64_stream_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder: one character in, decoded bytes out.
// ----------------------------------------------------------------------------
// One character is taken per beat, every cycle while in_ready is high. The
// front classifies it, gathers sextets and pushes each finished group (one to
// three bytes) into a short queue in the cycle of acceptance; the back sends
// one byte per cycle while out_ready is high. A group goes through the queue
// and the back's register before it is sent. Characters outside the alphabet,
// '=' included, are dropped, but their end_of_message flag still flushes the
// held group. in_ready falls only when the queue of QUEUE_DEPTH groups is
// full, which happens when the output side is stalled.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top #(
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_message,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic [7:0]      data_byte,
  output logic            last_of_run,
  output logic            message_done,
  output logic            out_valid,
  input  wire logic       out_ready
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  b64d_pkg::job_t q_in;
  b64d_pkg::job_t q_out;

  b64d_front u_front (
    .clk            (clk),
    .rst            (rst),
    .char_code      (char_code),
    .end_of_message (end_of_message),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .data_byte    (data_byte),
    .last_of_run  (last_of_run),
    .message_done (message_done),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule
`default_nettype wire
